/* hw/rtl/ubdc_pkg.sv */
package ubdc_pkg;

    // one quotient bit per cell, dividend and divisor both fit 32 bits
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned REM_W     = DIV_W + 1;

    localparam int unsigned CLK_W   = 26;
    localparam int unsigned BAUD_W  = 22;
    localparam int unsigned TOL_W   = 13;
    localparam int unsigned IN_W    = 24;
    localparam int unsigned OUT_W   = 48;
    localparam int unsigned CFG_A_W = 2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_X16     = 2'd0;
    localparam t_mode MODE_X4      = 2'd2;
    localparam t_mode MODE_SAMPLED = 2'd3;

    typedef logic [CFG_A_W-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_CLOCK_RATE  = 2'd0;
    localparam t_cfg_addr CFG_FORCE_HS    = 2'd1;
    localparam t_cfg_addr CFG_UPSTREAM    = 2'd2;

    localparam logic [CLK_W-1:0]  CLK_RESET       = 26'd26000000;
    localparam logic [CLK_W-1:0]  SPECIAL_CLOCK   = 26'd12000000;
    localparam logic [BAUD_W-1:0] LOW_SPEED_LIMIT = 22'd115200;
    localparam logic [BAUD_W-1:0] X4_LIMIT        = 22'd576000;
    localparam logic [BAUD_W-1:0] X4_SUBSTITUTE   = 22'd460800;
    localparam logic [BAUD_W-1:0] X4_ODD_RATE     = 22'd500000;

    // floor(x / 100) for x below 2^19 as (x * RECIP_100) >> 26
    localparam logic [19:0] RECIP_100 = 20'd671089;
    // floor(v / 10) for v below 128 as (v * RECIP_10) >> 11
    localparam logic [7:0]  RECIP_10  = 8'd205;

    typedef struct packed {
        logic [CLK_W-1:0]  clk;
        logic [BAUD_W-1:0] baud;
        t_mode             mode;
        logic              special;
        logic [DIV_W-1:0]  quot;
        logic [DIV_W-1:0]  samp;
        logic [TOL_W-1:0]  tol;
    } t_ctx;

    typedef struct packed {
        logic             vld;
        t_ctx             ctx;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } t_dstep;

    function automatic logic [7:0] frac_low_lut(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h05;
            4'd3:    v = 8'h15;
            4'd4:    v = 8'h55;
            4'd5:    v = 8'h57;
            4'd6:    v = 8'h57;
            4'd7:    v = 8'h77;
            4'd8:    v = 8'h7F;
            4'd9:    v = 8'hFF;
            4'd10:   v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] frac_high_lut(input logic [3:0] idx);
        logic [1:0] v;
        unique case (idx)
            4'd6, 4'd7, 4'd8, 4'd9: v = 2'd1;
            4'd10:                  v = 2'd3;
            default:                v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/ubdc_div_cell.sv */
module ubdc_div_cell
    import ubdc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_dstep i_step,
    output t_dstep o_step
);

    t_dstep           r_step;
    t_dstep           n_step;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    // one restoring step: bring down the next dividend bit and try the divisor
    always_comb begin
        w_trial = {i_step.rem[DIV_W-1:0], i_step.num[DIV_W-1]};
        w_ge    = w_trial >= {1'b0, i_step.den};
        n_step      = i_step;
        n_step.rem  = w_ge ? (w_trial - {1'b0, i_step.den}) : w_trial;
        n_step.num  = {i_step.num[DIV_W-2:0], 1'b0};
        n_step.quo  = {i_step.quo[DIV_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step.vld <= 1'b0;
        end else if (i_en) begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

/* hw/rtl/ubdc_div_chain.sv */
module ubdc_div_chain
    import ubdc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_dstep i_step,
    output t_dstep o_step
);

    t_dstep w_link [DIV_STEPS+1];

    assign w_link[0] = i_step;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        ubdc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_step  (w_link[g]),
            .o_step  (w_link[g+1])
        );
    end

    assign o_step = w_link[DIV_STEPS];

endmodule

/* hw/rtl/uart_baud_divisor_calc_core.sv */
// uart baud divisor calculator
//
// slave stream takes one word per request: tdata[21:0] is the baud rate.
// master stream returns one word per request, in order. the config port
// writes clock_rate (index 0), force_high_speed (1) and upstream_rule (2);
// only write it while no request is in flight.
//
// the datapath is three chains of 32 restoring divider cells, one quotient
// bit per cell, with a register stage in front of each chain and an output
// register; a new request is accepted every cycle while o_s_tready is high,
// that is, while the pipe is not stalled by the receiver.
//
// reset clears all valid flags and loads clock_rate 26000000, both mode
// flags 0. when the receiver stalls, the result holds in the output register
// and the pipe keeps moving until its last stage is occupied; only then does
// o_s_tready fall, so empty slots in front of the next word drain out first.
module uart_baud_divisor_calc_core
    import ubdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [IN_W-1:0]    i_s_tdata,    // baud[21:0], zero pad
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [OUT_W-1:0]   o_m_tdata,    // speed_mode[1:0], divisor[17:2],
                                             // samp_cnt[25:18],
                                             // samp_pt[33:26],
                                             // frac_low[41:34], frac_high[43:42],
                                             // out_of_tolerance[44], zero pad
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CLK_W-1:0]   i_cfg_wdata
);

    logic [CLK_W-1:0] r_clock_rate;
    logic             r_force_hs;
    logic             r_upstream;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= CLK_RESET;
            r_force_hs   <= 1'b0;
            r_upstream   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CLOCK_RATE: r_clock_rate <= i_cfg_wdata;
                CFG_FORCE_HS:   r_force_hs   <= i_cfg_wdata[0];
                CFG_UPSTREAM:   r_upstream   <= i_cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    logic   w_en;
    t_dstep r_a, n_a, w_c1, r_b, n_b, w_c2, r_c, n_c, w_c3;
    logic   r_o_vld;
    logic [OUT_W-1:0] r_o_data, n_o_data;

    // pipe moves unless the last stage holds a word and the output is blocked
    assign w_en       = !r_o_vld || i_m_tready || !w_c3.vld;
    assign o_s_tready = w_en;

    // decode: pick the mode, first divisor and rounding offset
    always_comb begin
        logic [BAUD_W-1:0] b0, b;
        logic              special, gen, m0, m2;
        logic [DIV_W-1:0]  d1, c32;
        b0      = (i_s_tdata[BAUD_W-1:0] == '0) ? BAUD_W'(1) : i_s_tdata[BAUD_W-1:0];
        special = (b0 <= LOW_SPEED_LIMIT) && (r_clock_rate == SPECIAL_CLOCK);
        gen     = !special && (r_force_hs || (r_upstream && b0 >= LOW_SPEED_LIMIT));
        m0      = !special && !gen && (b0 <= LOW_SPEED_LIMIT);
        m2      = !special && !gen && !m0 && (b0 <= X4_LIMIT);
        b       = (m2 && (b0 == X4_ODD_RATE || b0 == X4_LIMIT)) ? X4_SUBSTITUTE : b0;
        c32     = {{(DIV_W-CLK_W){1'b0}}, r_clock_rate};
        if (m0) begin
            d1 = {6'b0, b, 4'b0};
        end else if (m2) begin
            d1 = {8'b0, b, 2'b0};
        end else begin
            d1 = {2'b0, b, 8'b0};
        end
        n_a             = '0;
        n_a.vld         = i_s_tvalid;
        n_a.ctx.clk     = r_clock_rate;
        n_a.ctx.baud    = b;
        n_a.ctx.special = special;
        n_a.ctx.mode    = m0 ? MODE_X16 : (m2 ? MODE_X4 : MODE_SAMPLED);
        n_a.den         = d1;
        // round for x16 and the 12 MHz case, ceil otherwise
        n_a.num         = (special || m0) ? (c32 + (d1 >> 1)) : (c32 + d1 - DIV_W'(1));
    end

    // after the first divide: saturate, second divisor, tolerance band
    always_comb begin
        logic [DIV_W-1:0]  q1;
        logic [45:0]       d2p;
        logic [DIV_W-1:0]  d2, c32;
        logic [18:0]       x3;
        logic [38:0]       tp;
        q1  = (w_c1.ctx.mode == MODE_SAMPLED && w_c1.quo == '0) ? DIV_W'(1) : w_c1.quo;
        d2p = q1[23:0] * w_c1.ctx.baud;
        d2  = d2p[DIV_W-1:0];
        c32 = {{(DIV_W-CLK_W){1'b0}}, w_c1.ctx.clk};
        x3  = 19'(w_c1.ctx.baud[16:0]) * 19'd3;
        tp  = x3 * RECIP_100;
        n_b          = '0;
        n_b.vld      = w_c1.vld;
        n_b.ctx      = w_c1.ctx;
        n_b.ctx.quot = q1;
        n_b.ctx.tol  = tp[38:26];
        n_b.den      = d2;
        n_b.num      = w_c1.ctx.special ? (c32 + (d2 >> 1)) : c32;
    end

    // after the second divide: real-rate check or hundredths of the remainder
    always_comb begin
        logic [50:0]      sq;
        logic [DIV_W-1:0] r100;
        sq   = w_c2.quo[26:0] * w_c2.ctx.quot[23:0];
        r100 = w_c2.rem[DIV_W-1:0] * DIV_W'(100);
        n_c          = '0;
        n_c.vld      = w_c2.vld;
        n_c.ctx      = w_c2.ctx;
        n_c.ctx.samp = w_c2.quo;
        n_c.den      = w_c2.ctx.special ? sq[DIV_W-1:0] : w_c2.den;
        n_c.num      = w_c2.ctx.special
                       ? {{(DIV_W-CLK_W){1'b0}}, w_c2.ctx.clk} : r100;
    end

    // result assembly
    always_comb begin
        t_ctx             x;
        logic [7:0]       cnt, pnt, fl;
        logic [1:0]       fh;
        logic             flag;
        logic [6:0]       v;
        logic [14:0]      vp;
        logic [3:0]       idx;
        logic [DIV_W-1:0] rl;
        logic [BAUD_W:0]  hi, lo;
        x    = w_c3.ctx;
        cnt  = 8'h00;
        pnt  = 8'hFF;
        fl   = 8'h00;
        fh   = 2'd0;
        flag = 1'b0;
        v    = w_c3.quo[6:0] + 7'd5;
        vp   = 15'(v) * 15'(RECIP_10);
        idx  = vp[14:11];
        rl   = (x.samp == '0) ? '0 : w_c3.quo;
        hi   = {1'b0, x.baud} + (BAUD_W+1)'(x.tol);
        lo   = {1'b0, x.baud} - (BAUD_W+1)'(x.tol);
        if (x.mode == MODE_SAMPLED) begin
            cnt = x.samp[7:0] - 8'd1;
            pnt = x.samp[8:1] - 8'd1;
            if (x.special) begin
                flag = (rl > DIV_W'(hi)) || (rl < DIV_W'(lo));
            end else begin
                fl = frac_low_lut(idx);
                fh = frac_high_lut(idx);
            end
        end
        n_o_data = {3'b0, flag, fh, fl, pnt, cnt, x.quot[15:0], x.mode};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
            r_b.vld <= 1'b0;
            r_c.vld <= 1'b0;
        end else if (w_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (!r_o_vld || i_m_tready) begin
            r_o_vld <= w_c3.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || i_m_tready) begin
            r_o_data <= n_o_data;
        end
    end

    ubdc_div_chain u_div1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_step (r_a), .o_step (w_c1)
    );

    ubdc_div_chain u_div2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_step (r_b), .o_step (w_c2)
    );

    ubdc_div_chain u_div3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_step (r_c), .o_step (w_c3)
    );

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;

endmodule

/* hw/rtl/ubdc_checker.sv */
module ubdc_checker
    import ubdc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [OUT_W-1:0]   o_m_tdata
);

    // a held word does not vanish
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // x16 and x4 modes carry a unit sample count and no fraction
    a_plain_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == MODE_X16 || o_m_tdata[1:0] == MODE_X4)
        |-> o_m_tdata[25:18] == 8'h00 && o_m_tdata[33:26] == 8'hFF
            && o_m_tdata[43:34] == '0 && !o_m_tdata[44])
        else $error("plain mode with sampling fields set");

    a_no_mode1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd1)
        else $error("unused speed mode reported");

    // a stalled word keeps its contents
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output word changed while stalled");

endmodule

bind uart_baud_divisor_calc_core ubdc_checker u_ubdc_checker (.*);
